// ----- src/rgbg_pkg.sv -----
// Package for the RGB to gray converter: widths, mode and register codes,
// fixed luma weights and the weight selection function.
// No dependencies.
package rgbg_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WEIGHT_W   = 16;
	localparam int COEF_W     = WEIGHT_W + 2;          // Q2.16 signed
	localparam int PROD_W     = COEF_W + PIX_W + 1;
	localparam int SUM_W      = PROD_W + 1;
	localparam int FRAC_W     = 16;

	typedef enum logic [2:0] {
		MODE_AVERAGE = 3'd0,
		MODE_LUMA601 = 3'd1,
		MODE_LUMA709 = 3'd2,
		MODE_CUSTOM  = 3'd3,
		MODE_DESAT   = 3'd4,
		MODE_VALUE   = 3'd5
	} gray_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAY_MODE    = 2'd0,
		REG_WEIGHT_RED   = 2'd1,
		REG_WEIGHT_GREEN = 2'd2,
		REG_WEIGHT_BLUE  = 2'd3
	} cfg_reg_t;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	typedef struct packed {
		coef_t red;
		coef_t green;
		coef_t blue;
	} coef_set_t;

	localparam gray_mode_t MODE_RESET         = MODE_LUMA601;
	localparam weight_t    WEIGHT_RED_RESET   = 16'sd4899;
	localparam weight_t    WEIGHT_GREEN_RESET = 16'sd9617;
	localparam weight_t    WEIGHT_BLUE_RESET  = 16'sd1868;

	// 21846/65536 is close enough to 1/3 that floor is exact for sums up to 765
	localparam coef_t AVG_COEF   = 18'sd21846;
	localparam coef_t L601_RED   = 18'sd19595;
	localparam coef_t L601_GREEN = 18'sd38470;
	localparam coef_t L601_BLUE  = 18'sd7471;
	localparam coef_t L709_RED   = 18'sd13933;
	localparam coef_t L709_GREEN = 18'sd46871;
	localparam coef_t L709_BLUE  = 18'sd4732;

	// All weighted modes share one Q.16 sum; custom Q2.14 weights are scaled by 4
	function automatic coef_set_t select_coefs(gray_mode_t mode, weight_t wr,
			weight_t wg, weight_t wb);
		coef_set_t c;
		case (mode)
			MODE_AVERAGE: c = '{AVG_COEF, AVG_COEF, AVG_COEF};
			MODE_LUMA601: c = '{L601_RED, L601_GREEN, L601_BLUE};
			MODE_LUMA709: c = '{L709_RED, L709_GREEN, L709_BLUE};
			MODE_CUSTOM:  c = '{signed'({wr, 2'b00}), signed'({wg, 2'b00}),
				signed'({wb, 2'b00})};
			default:      c = '{'0, '0, '0};
		endcase
		return c;
	endfunction

endpackage

// ----- src/rgbg_if.sv -----
// Valid/ready channel interfaces for the RGB to gray converter:
// pixel input channel and gray result channel. Uses rgbg_pkg.
interface rgbg_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [rgbg_pkg::PIX_W-1:0] red_in;
	logic [rgbg_pkg::PIX_W-1:0] green_in;
	logic [rgbg_pkg::PIX_W-1:0] blue_in;

	modport source(output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface rgbg_gray_if;
	logic                       valid;
	logic                       ready;
	logic [rgbg_pkg::PIX_W-1:0] gray_out;

	modport source(output valid, output gray_out, input ready);
	modport sink(input valid, input gray_out, output ready);
endinterface

// ----- src/rgbg_luma.sv -----
// Weighted channel sum: three signed multiplies and their sum, combinational.
// Depends on rgbg_pkg.
module rgbg_luma (
	input  logic [rgbg_pkg::PIX_W-1:0] red,
	input  logic [rgbg_pkg::PIX_W-1:0] green,
	input  logic [rgbg_pkg::PIX_W-1:0] blue,
	input  rgbg_pkg::coef_set_t        coefs,
	output rgbg_pkg::sum_t             sum
);
	import rgbg_pkg::*;

	logic signed [PROD_W-1:0] prod_r;
	logic signed [PROD_W-1:0] prod_g;
	logic signed [PROD_W-1:0] prod_b;

	// widen both operands first so the product keeps its full width
	always_comb begin
		prod_r = PROD_W'(coefs.red)   * PROD_W'(signed'({1'b0, red}));
		prod_g = PROD_W'(coefs.green) * PROD_W'(signed'({1'b0, green}));
		prod_b = PROD_W'(coefs.blue)  * PROD_W'(signed'({1'b0, blue}));
	end

	assign sum = SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);

endmodule

// ----- src/rgb_to_gray_multi_mode_unit.sv -----
// RGB to gray converter, six selectable methods.
// An accepted input goes through the input register, then the result register,
// before result valid. Throughput: one item per cycle; the input holds while a
// result waits on gray.ready.
// Reset clears the stage valids and loads mode luma601 and the default
// custom weights. Depends on rgbg_pkg, rgbg_if and rgbg_luma.
module rgb_to_gray_multi_mode_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rgbg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_data,
	rgbg_pixel_if.sink                      pix,
	rgbg_gray_if.source                     gray
);
	import rgbg_pkg::*;

	gray_mode_t mode_q;
	weight_t    weight_red_q;
	weight_t    weight_green_q;
	weight_t    weight_blue_q;

	logic             valid_s1, out_valid_q;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	logic [PIX_W-1:0] gray_q;

	logic             advance;
	logic [PIX_W-1:0] max_c, min_c, rg_max, rg_min;
	sum_t             luma_sum;
	logic [PIX_W:0]   mid_sum;
	logic [PIX_W-1:0] luma_sat;
	logic [PIX_W-1:0] result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_RESET;
			weight_red_q   <= WEIGHT_RED_RESET;
			weight_green_q <= WEIGHT_GREEN_RESET;
			weight_blue_q  <= WEIGHT_BLUE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRAY_MODE:    mode_q         <= gray_mode_t'(cfg_data[2:0]);
				REG_WEIGHT_RED:   weight_red_q   <= signed'(cfg_data[WEIGHT_W-1:0]);
				REG_WEIGHT_GREEN: weight_green_q <= signed'(cfg_data[WEIGHT_W-1:0]);
				REG_WEIGHT_BLUE:  weight_blue_q  <= signed'(cfg_data[WEIGHT_W-1:0]);
				default: ;
			endcase
		end
	end

	assign advance   = !out_valid_q || gray.ready;
	assign pix.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pix.valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pix.valid) begin
			red_s1   <= pix.red_in;
			green_s1 <= pix.green_in;
			blue_s1  <= pix.blue_in;
		end
	end

	// max / min of the three channels
	always_comb begin
		rg_max = (red_s1 > green_s1) ? red_s1 : green_s1;
		rg_min = (red_s1 < green_s1) ? red_s1 : green_s1;
		max_c  = (rg_max > blue_s1) ? rg_max : blue_s1;
		min_c  = (rg_min < blue_s1) ? rg_min : blue_s1;
	end

	rgbg_luma u_luma (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.coefs (select_coefs(mode_q, weight_red_q, weight_green_q, weight_blue_q)),
		.sum   (luma_sum)
	);

	always_comb begin
		// clamp only bites in custom mode; preset sums stay within 0..255
		if (luma_sum < 0)
			luma_sat = '0;
		else if (luma_sum[SUM_W-1:FRAC_W] > (SUM_W-FRAC_W)'(255))
			luma_sat = '1;
		else
			luma_sat = luma_sum[FRAC_W +: PIX_W];

		mid_sum = {1'b0, max_c} + {1'b0, min_c};

		case (mode_q)
			MODE_AVERAGE,
			MODE_LUMA601,
			MODE_LUMA709,
			MODE_CUSTOM: result = luma_sat;
			MODE_DESAT:  result = mid_sum[PIX_W:1];
			MODE_VALUE:  result = max_c;
			default:     result = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			gray_q <= result;
		end
	end

	assign gray.valid    = out_valid_q;
	assign gray.gray_out = gray_q;

endmodule

// ----- tb/sv/rgb_to_gray_multi_mode_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench for rgb_to_gray_multi_mode_unit: pixel streams under many mode and
// weight settings, each gray item checked against an in-bench gray predictor.
// Depends on rgbg_pkg, rgbg_if and the unit RTL.
module rgb_to_gray_multi_mode_unit_test;
	import rgbg_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 12;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 16;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int GAP_LIMIT       = 12;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rgbg_pixel_if pix_ch();
	rgbg_gray_if  gray_ch();

	rgb_to_gray_multi_mode_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.gray      (gray_ch)
	);

	// predictor copy of the registers
	logic [2:0] mode_now;
	weight_t    red_wt_now;
	weight_t    green_wt_now;
	weight_t    blue_wt_now;

	pixel_t           pixels_to_send[$];
	logic [PIX_W-1:0] gray_expected[$];
	pixel_t           seen_pix;
	logic [PIX_W-1:0] want_gray;
	bit               pix_fired;
	int               mismatches = 0;
	int               cycles = 0;
	// items queued but whose gray item has not come back yet
	int               pending = 0;

	int burst_left = 0;
	int gap_left = 0;
	int gap_max = GAP_LIMIT;
	pixel_t next_pix;

	int stall_pct = 0;
	int stall_span = 0;
	int hold_left = 0;
	int hold_off_asks = 0;
	int hold_off_seen = 0;

	function automatic logic [PIX_W-1:0] gray_of_pixel(pixel_t p);
		int r, g, b, hi, lo;
		longint s;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		case (mode_now)
			MODE_AVERAGE: return PIX_W'((r + g + b) / 3);
			MODE_LUMA601: return PIX_W'((19595 * r + 38470 * g + 7471 * b) >> 16);
			MODE_LUMA709: return PIX_W'((13933 * r + 46871 * g + 4732 * b) >> 16);
			MODE_CUSTOM: begin
				s = longint'(red_wt_now) * r + longint'(green_wt_now) * g
					+ longint'(blue_wt_now) * b;
				if (s < 0)
					return '0;
				s = s >>> 14;
				return (s > 255) ? 8'd255 : s[7:0];
			end
			MODE_DESAT:   return PIX_W'((hi + lo) / 2);
			MODE_VALUE:   return PIX_W'(hi);
			default:      return '0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d gray items still expected", $time,
				gray_expected.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// input accepts feed the predictor; output accepts are checked in order
	always @(posedge clk) begin
		pix_fired = arst_n && pix_ch.valid && pix_ch.ready;
		if (pix_fired) begin
			seen_pix.red = pix_ch.red_in;
			seen_pix.green = pix_ch.green_in;
			seen_pix.blue = pix_ch.blue_in;
			gray_expected.push_back(gray_of_pixel(seen_pix));
		end
		if (arst_n && gray_ch.valid && gray_ch.ready) begin
			pending--;
			if (gray_expected.size() == 0) begin
				mismatches++;
				$display("%0t: gray item %0d arrived with none expected", $time,
					gray_ch.gray_out);
			end else begin
				want_gray = gray_expected.pop_front();
				if (gray_ch.gray_out !== want_gray) begin
					mismatches++;
					$display("%0t: gray_out expected %0d actual %0d", $time, want_gray,
						gray_ch.gray_out);
				end
			end
		end
	end

	// pixel sender: bursts of random length, random gaps in between
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_fired) begin
			if (gap_left > 0) begin
				gap_left--;
				pix_ch.valid <= 1'b0;
				pix_ch.red_in <= PIX_W'($urandom_range(0, 255));
				pix_ch.green_in <= PIX_W'($urandom_range(0, 255));
				pix_ch.blue_in <= PIX_W'($urandom_range(0, 255));
			end else if (pixels_to_send.size() > 0) begin
				next_pix = pixels_to_send.pop_front();
				pix_ch.valid <= 1'b1;
				pix_ch.red_in <= next_pix.red;
				pix_ch.green_in <= next_pix.green;
				pix_ch.blue_in <= next_pix.blue;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
				end
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// gray receiver: stall rate changes over spans; long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			gray_ch.ready <= 1'b0;
		end else begin
			if (hold_off_seen != hold_off_asks) begin
				hold_off_seen = hold_off_asks;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (stall_span == 0) begin
				stall_span = $urandom_range(16, 128);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					2:       stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			stall_span--;
			if (hold_left > 0) begin
				hold_left--;
				gray_ch.ready <= 1'b0;
			end else begin
				gray_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_GRAY_MODE:    mode_now = data[2:0];
			REG_WEIGHT_RED:   red_wt_now = data;
			REG_WEIGHT_GREEN: green_wt_now = data;
			REG_WEIGHT_BLUE:  blue_wt_now = data;
			default: ;
		endcase
	endtask

	// mode code with junk in the bits above the mode field
	task automatic write_mode(logic [2:0] mode);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[2:0] = mode;
		write_reg(REG_GRAY_MODE, data);
	endtask

	task automatic wait_drained();
		while (pending > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_pixel(int r, int g, int b);
		pixel_t p;
		p.red = PIX_W'(r);
		p.green = PIX_W'(g);
		p.blue = PIX_W'(b);
		pixels_to_send.push_back(p);
		pending++;
	endtask

	function automatic int pick_channel();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic weight_t pick_weight();
		case ($urandom_range(0, 5))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			3:       return WEIGHT_W'($urandom_range(0, 16384));
			4:       return WEIGHT_W'($urandom);
			default: return WEIGHT_W'($urandom_range(0, 8000) - 2000);
		endcase
	endfunction

	initial begin
		int c;
		logic [2:0] mode;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red_in = '0;
		pix_ch.green_in = '0;
		pix_ch.blue_in = '0;
		gray_ch.ready = 1'b0;
		mode_now = MODE_RESET;
		red_wt_now = WEIGHT_RED_RESET;
		green_wt_now = WEIGHT_GREEN_RESET;
		blue_wt_now = WEIGHT_BLUE_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings first, then every mode code including the spare ones
		push_pixel(255, 0, 128);
		wait_drained();
		for (int m = 0; m < 8; m++) begin
			write_mode(3'(m));
			push_pixel(0, 0, 0);
			push_pixel(255, 255, 255);
			push_pixel(255, 0, 128);
			wait_drained();
		end

		// custom weights at both extremes: saturate high, then low
		write_mode(MODE_CUSTOM);
		write_reg(REG_WEIGHT_RED, 16'sh7FFF);
		write_reg(REG_WEIGHT_GREEN, 16'sh7FFF);
		write_reg(REG_WEIGHT_BLUE, 16'sh7FFF);
		push_pixel(255, 255, 255);
		wait_drained();
		write_reg(REG_WEIGHT_RED, 16'sh8000);
		write_reg(REG_WEIGHT_GREEN, 16'sh8000);
		write_reg(REG_WEIGHT_BLUE, 16'sh8000);
		push_pixel(255, 255, 255);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 8)
				mode = 3'(ph);
			else if ($urandom_range(0, 2) == 0)
				mode = MODE_CUSTOM;
			else
				mode = 3'($urandom_range(0, 7));
			write_reg(REG_WEIGHT_RED, pick_weight());
			write_reg(REG_WEIGHT_GREEN, pick_weight());
			write_reg(REG_WEIGHT_BLUE, pick_weight());
			write_mode(mode);
			gap_max = (ph == 2 || ph == 3) ? 0 : $urandom_range(1, GAP_LIMIT);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					c = pick_channel();
					push_pixel(c, c, c);
				end else begin
					push_pixel(pick_channel(), pick_channel(), pick_channel());
				end
			end
			// sender keeps offering while the receiver holds off
			if (ph == 3)
				hold_off_asks++;
			wait_drained();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
src/rgbg_pkg.sv
src/rgbg_if.sv
src/rgbg_luma.sv
src/rgb_to_gray_multi_mode_unit.sv
tb/sv/rgb_to_gray_multi_mode_unit_test.sv
